/* sv/lev_pkg.sv */
package lev_pkg;

	localparam int CordicSteps = 14;
	localparam int MaxSteps = 20;
	localparam int NSteps = (CordicSteps < MaxSteps) ? CordicSteps : MaxSteps;
	localparam int StepW = $clog2(NSteps + 1);
	localparam int SensorCount = 32;
	localparam int SensW = $clog2(SensorCount);

	localparam logic [31:0] MaskLeft = 32'hF000001F;
	localparam logic [31:0] MaskRight = 32'h001FF000;
	localparam logic [31:0] MaskMiddle = 32'h000003E0;
	localparam logic [15:0] Deg = 16'd128;
	localparam logic [15:0] FullTurn = 16'd46080;
	localparam logic [15:0] HalfTurn = 16'd23040;
	localparam logic [15:0] Deg45 = 16'd5760;
	localparam logic [15:0] Deg90 = 16'd11520;
	localparam logic [15:0] Deg135 = 16'd17280;
	localparam logic [15:0] Deg225 = 16'd28800;
	localparam logic signed [31:0] GainInvQ30 = 32'sd652032874;

	typedef enum logic [1:0] {
		REG_THRESH = 2'd0,
		REG_SPEED  = 2'd1,
		REG_CORNER = 2'd2,
		REG_FRONT  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] line_state;
		logic [11:0] front_raw;
	} in_item_t;

	typedef struct packed {
		logic               moving;
		logic               emergency;
		logic [15:0]        escape_angle;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  thresh;
		logic [6:0]  speed;
		logic [6:0]  corner_vy;
		logic [11:0] front_th;
	} cfg_t;

	// classified request handed from front to back
	typedef struct packed {
		logic              active;
		logic              clear;
		logic              corner;
		logic signed [20:0] sx;
		logic signed [20:0] sy;
	} job_t;

	function automatic logic signed [15:0] quarter_cos(input logic [3:0] r);
		unique case (r)
			4'd0: quarter_cos = 16'sd16384;
			4'd1: quarter_cos = 16'sd16069;
			4'd2: quarter_cos = 16'sd15137;
			4'd3: quarter_cos = 16'sd13623;
			4'd4: quarter_cos = 16'sd11585;
			4'd5: quarter_cos = 16'sd9102;
			4'd6: quarter_cos = 16'sd6270;
			4'd7: quarter_cos = 16'sd3196;
			default: quarter_cos = 16'sd0;
		endcase
	endfunction

	function automatic logic signed [15:0] unit_cos(input logic [4:0] k);
		logic [1:0] q;
		logic [3:0] r;
		q = k[4:3];
		r = {1'b0, k[2:0]};
		unique case (q)
			2'd0: unit_cos = quarter_cos(r);
			2'd1: unit_cos = -quarter_cos(4'd8 - r);
			2'd2: unit_cos = -quarter_cos(r);
			default: unit_cos = quarter_cos(4'd8 - r);
		endcase
	endfunction

	function automatic logic [22:0] atan_fine(input logic [4:0] i);
		unique case (i)
			5'd0: atan_fine = 23'd2949120;
			5'd1: atan_fine = 23'd1740967;
			5'd2: atan_fine = 23'd919879;
			5'd3: atan_fine = 23'd466945;
			5'd4: atan_fine = 23'd234379;
			5'd5: atan_fine = 23'd117304;
			5'd6: atan_fine = 23'd58666;
			5'd7: atan_fine = 23'd29335;
			5'd8: atan_fine = 23'd14668;
			5'd9: atan_fine = 23'd7334;
			5'd10: atan_fine = 23'd3667;
			5'd11: atan_fine = 23'd1833;
			5'd12: atan_fine = 23'd917;
			5'd13: atan_fine = 23'd458;
			5'd14: atan_fine = 23'd229;
			5'd15: atan_fine = 23'd115;
			5'd16: atan_fine = 23'd57;
			5'd17: atan_fine = 23'd29;
			5'd18: atan_fine = 23'd14;
			5'd19: atan_fine = 23'd7;
			default: atan_fine = 23'd0;
		endcase
	endfunction

endpackage

/* sv/lev_front.sv */
module lev_front import lev_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  item,
	input  logic      start,
	input  cfg_t      cfg,
	output logic      busy,
	output logic      job_valid,
	output job_t      job,
	input  logic      job_take
);
	// walk the ring one sensor a cycle, summing unit vectors
	typedef enum logic [1:0] {F_IDLE, F_SUM, F_OUT} fstate_t;

	fstate_t            state_q;
	logic [31:0]        ls_q;
	logic [SensW-1:0]   idx_q;
	logic signed [20:0] sx_q, sy_q;
	logic               any_q, corner_q, mid_q;
	logic [4:0]         k;
	logic               left, right;

	assign k = idx_q;
	assign left = (item.line_state & MaskLeft) != MaskLeft;
	assign right = (item.line_state & MaskRight) != MaskRight;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (start) begin
					ls_q <= item.line_state;
					idx_q <= '0;
					sx_q <= '0;
					sy_q <= '0;
					any_q <= 1'b0;
					mid_q <= (item.line_state & MaskMiddle) != MaskMiddle;
					corner_q <= (left != right) && (item.front_raw >= cfg.front_th);
					state_q <= ((item.line_state & MaskMiddle) != MaskMiddle) ? F_OUT : F_SUM;
				end
				F_SUM: begin
					if (!ls_q[k]) begin
						sx_q <= sx_q + 21'(unit_cos(k));
						sy_q <= sy_q + 21'(unit_cos(k + 5'd24));
						any_q <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == SensW'(SensorCount - 1)) state_q <= F_OUT;
				end
				F_OUT: if (job_take) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign busy = state_q != F_IDLE;
	assign job_valid = state_q == F_OUT;
	always_comb begin
		job.active = !mid_q && any_q;
		job.clear = !mid_q && !any_q;
		job.corner = corner_q;
		job.sx = sx_q;
		job.sy = sy_q;
	end
endmodule

/* sv/lev_back.sv */
module lev_back import lev_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	input  job_t      job,
	output logic      job_take,
	input  cfg_t      cfg,
	output logic      res_valid,
	output out_item_t res,
	input  logic      res_take
);
	typedef enum logic [2:0] {B_IDLE, B_VEC, B_ANG, B_ROT, B_DONE} bstate_t;

	bstate_t            state_q;
	logic [StepW-1:0]   it_q;
	logic signed [40:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic               seen_q, flip_q, emerg_q, corner_q;
	logic [15:0]        first_q, fin_q;
	logic [15:0]        cur;
	logic signed [31:0] zr;
	logic signed [31:0] qz;
	logic [15:0]        diff, dabs, base, fin0, fin;
	logic signed [40:0] dx, dy, vyr, vxr;
	logic signed [40:0] x0;
	logic signed [31:0] at;

	assign at = 32'(atan_fine(5'(it_q)));
	assign dx = y_q >>> it_q;
	assign dy = x_q >>> it_q;

	// round to Q9.7 and wrap
	always_comb begin
		zr = (z_q + 32'sd256) >>> 9;
		qz = zr;
		if (zr < 0) qz = zr + 32'(FullTurn);
		else if (zr >= 32'(FullTurn)) qz = zr - 32'(FullTurn);
		cur = qz[15:0];
	end

	always_comb begin
		logic [15:0] fa;
		fa = seen_q ? first_q : cur;
		dabs = (cur >= fa) ? cur - fa : fa - cur;
		diff = (dabs > HalfTurn) ? FullTurn - dabs : dabs;
		base = (diff > {cfg.thresh, 7'd0}) ? fa : cur;
		fin0 = (base >= HalfTurn) ? base - HalfTurn : base + HalfTurn;
		if (fin0 >= Deg45 && fin0 < Deg135) fin = Deg90;
		else if (fin0 >= Deg135 && fin0 < Deg225) fin = HalfTurn;
		else fin = fin0;
	end

	always_comb begin
		x0 = (41'($signed({1'b0, cfg.speed})) * 41'(GainInvQ30)) >>> 6;
	end

	function automatic logic signed [15:0] sat16(input logic signed [40:0] v);
		if (v > 41'sd32767) sat16 = 16'sh7fff;
		else if (v < -41'sd32768) sat16 = 16'sh8000;
		else sat16 = v[15:0];
	endfunction

	always_comb begin
		vxr = (x_q + 41'sd32768) >>> 16;
		vyr = (y_q + 41'sd65536) >>> 17;
	end

	assign job_take = state_q == B_IDLE && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			seen_q <= 1'b0;
			first_q <= '0;
			res_valid <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: if (job_valid) begin
					corner_q <= job.corner;
					if (job.clear) seen_q <= 1'b0;
					if (job.active) begin
						it_q <= '0;
						if (job.sx == 0 && job.sy == 0) begin
							x_q <= '0; y_q <= '0; z_q <= '0;
							state_q <= B_ANG;
						end else if (job.sx < 0) begin
							x_q <= -41'(job.sx); y_q <= -41'(job.sy);
							z_q <= 32'sd11796480;
							state_q <= B_VEC;
						end else begin
							x_q <= 41'(job.sx); y_q <= 41'(job.sy); z_q <= '0;
							state_q <= B_VEC;
						end
					end else begin
						res <= '0;
						res_valid <= 1'b1;
						state_q <= B_DONE;
					end
				end
				B_VEC: begin
					if (y_q > 0) begin
						x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
					end else begin
						x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
					end
					it_q <= it_q + 1'b1;
					if (it_q == StepW'(NSteps - 1)) state_q <= B_ANG;
				end
				B_ANG: begin
					if (!seen_q) first_q <= cur;
					seen_q <= 1'b1;
					emerg_q <= diff > {cfg.thresh, 7'd0};
					fin_q <= fin;
					it_q <= '0;
					x_q <= x0; y_q <= '0;
					state_q <= B_ROT;
					flip_q <= 1'b0;
					if (32'(fin) << 9 > 32'sd5898240 && 32'(fin) << 9 <= 32'sd17694720) begin
						z_q <= (32'(fin) <<< 9) - 32'sd11796480;
						flip_q <= 1'b1;
					end else if (32'(fin) << 9 > 32'sd17694720) begin
						z_q <= (32'(fin) <<< 9) - 32'sd23592960;
					end else z_q <= 32'(fin) <<< 9;
				end
				B_ROT: begin
					if (it_q == StepW'(NSteps)) begin
						res.moving <= 1'b1;
						res.emergency <= emerg_q;
						res.escape_angle <= fin_q;
						res.vel_x <= sat16(flip_q ? -vxr + ((x_q[15:0] == 16'h8000) ? 41'sd1 : 41'sd0) : vxr);
						res.vel_y <= corner_q ? 16'({cfg.corner_vy, 8'd0})
							: sat16(flip_q ? -vyr + ((y_q[16:0] == 17'h10000) ? 41'sd1 : 41'sd0) : vyr);
						res_valid <= 1'b1;
						state_q <= B_DONE;
					end else begin
						if (z_q >= 0) begin
							x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
						end else begin
							x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
						end
						it_q <= it_q + 1'b1;
					end
				end
				B_DONE: if (res_take) begin
					res_valid <= 1'b0;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) job_take |=> state_q != B_IDLE)
		else $error("back took request but stayed idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_take) |=> res_valid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_VEC) |-> it_q < StepW'(NSteps))
		else $error("cordic count overrun");
endmodule

/* sv/line_escape_vector.sv */
// Line escape vector computer.
// Input channel: push/full with item {line_state, front_raw}; taken when push && !full.
// Result channel: empty/pop; the oldest result sits on result while empty is low,
// and is taken when pop && !empty.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 threshold, 1 speed,
// 2 corner_vy, 3 front threshold) and cfg_data; write only while idle.
// Flow: the front scans 32 sensors, one per cycle, and offers its request in
// F_OUT until the back, when idle, takes it; the back then runs CORDIC
// vectoring, a setup state (B_ANG) and CORDIC rotation plus an output step,
// and holds the result in B_DONE until it is popped.
// Items with a middle sensor on the line skip the scan; their result is all
// zero and skips CORDIC.
// Overlap: one item at a time per part; the front may scan the next item
// while the back finishes the previous one.
// Reset: registers return to 90/40/20/2048, the first-angle latch clears,
// both channels empty.
// Receiver stall: the result holds; the back waits and the front then holds
// its finished request, which raises full.
module line_escape_vector import lev_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	cfg_t cfg_q;
	logic busy, job_valid, job_take, res_valid;
	job_t job;

	// register file: accept writes every cycle
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thresh <= 8'd90;
			cfg_q.speed <= 7'd40;
			cfg_q.corner_vy <= 7'd20;
			cfg_q.front_th <= 12'd2048;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_THRESH: cfg_q.thresh <= cfg_data[7:0];
				REG_SPEED:  cfg_q.speed <= cfg_data[6:0];
				REG_CORNER: cfg_q.corner_vy <= cfg_data[6:0];
				REG_FRONT:  cfg_q.front_th <= cfg_data;
				default: ;
			endcase
		end
	end

	// front is the only entry point; hold off pushes while it works
	assign full = busy;

	lev_front u_front (
		.clk, .arst_n, .item, .start(push && !busy), .cfg(cfg_q),
		.busy, .job_valid, .job, .job_take
	);

	lev_back u_back (
		.clk, .arst_n, .job_valid, .job, .job_take, .cfg(cfg_q),
		.res_valid, .res(result), .res_take(pop)
	);

	assign empty = !res_valid;
endmodule
